### rtl/fbv_pkg.sv
// Package for the frustum box visibility block.
// Holds widths, codes and shared types; no dependencies.
package fbv_pkg;

  localparam int NUM_PLANES   = 6;
  localparam int BOX_CORNERS  = 8;
  localparam int COORD_W      = 16;
  localparam int PROD_W       = 2 * COORD_W;
  localparam int SUM_W        = PROD_W + 3;
  localparam int BEHIND_LIMIT = 8388;
  localparam int PLANE_W      = 64;
  localparam int CORNER_W     = $clog2(BOX_CORNERS);
  localparam int PIU_W        = 3;

  // Test selector codes carried on the input tuser.
  localparam logic [1:0] FUNC_POINT  = 2'd0;
  localparam logic [1:0] FUNC_BOX    = 2'd1;
  localparam logic [1:0] FUNC_CORNER = 2'd2;

  // Visibility codes.
  localparam logic [1:0] VIS_INVISIBLE = 2'd0;
  localparam logic [1:0] VIS_PARTIAL   = 2'd1;
  localparam logic [1:0] VIS_FULL      = 2'd2;

  // Register index on the configuration port and the planes_in_use reset value.
  localparam logic [2:0] REG_PLANES_IN_USE = 3'd6;
  localparam logic [PIU_W-1:0] PIU_RESET   = 3'd6;

  typedef logic [2:0][COORD_W-1:0] coord3_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] func;
  } ctrl_t;

endpackage

### rtl/fbv_lane.sv
// One plane lane: products of the plane normal with the box bounds, then the
// eight corner distances and their behind flags. Depends on fbv_pkg.
module fbv_lane import fbv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 advance_i,
  input  logic [PLANE_W-1:0]   plane_i,
  input  coord3_t              lo_i,
  input  coord3_t              hi_i,
  output logic [BOX_CORNERS-1:0] behind_o
);

  localparam logic signed [SUM_W-1:0] BEHIND_THRESH = -SUM_W'(BEHIND_LIMIT);

  logic signed [PROD_W-1:0]      prod_d [3][2];
  logic signed [PROD_W-1:0]      prod_q [3][2];
  logic [BOX_CORNERS-1:0]        behind_d, behind_q;
  logic signed [SUM_W-1:0]       d_term;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod_d[a][0] = $signed(lo_i[a]) * $signed(plane_i[a*COORD_W +: COORD_W]);
      prod_d[a][1] = $signed(hi_i[a]) * $signed(plane_i[a*COORD_W +: COORD_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      prod_q <= prod_d;
    end
  end

  // The offset d is Q8.8; shifting it by 14 brings it to the product scale.
  assign d_term = $signed({{(SUM_W-COORD_W-14){plane_i[PLANE_W-1]}},
                           plane_i[PLANE_W-1 -: COORD_W], 14'b0});

  always_comb begin
    logic signed [SUM_W-1:0] sum;
    for (int c = 0; c < BOX_CORNERS; c++) begin
      sum = SUM_W'(prod_q[0][c % 2]) + SUM_W'(prod_q[1][(c / 2) % 2])
          + SUM_W'(prod_q[2][(c / 4) % 2]) + d_term;
      behind_d[c] = (sum < BEHIND_THRESH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      behind_q <= behind_d;
    end
  end

  assign behind_o = behind_q;

endmodule

### rtl/fbv_merge.sv
// Merge stage: combines the behind flags of all plane lanes into a visibility
// code, keeps the streamed-corner state, and holds the output register.
// Depends on fbv_pkg.
module fbv_merge import fbv_pkg::*; (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 advance_i,
  input  ctrl_t                                ctrl_i,
  input  logic [NUM_PLANES-1:0][BOX_CORNERS-1:0] behind_i,
  input  logic [PIU_W-1:0]                     planes_in_use_i,
  output logic                                 valid_o,
  output logic [1:0]                           vis_o
);

  logic [NUM_PLANES-1:0] active;
  logic [PIU_W-1:0]      n_active;
  logic [NUM_PLANES-1:0] all_q, all_d, any_q, any_d;
  logic [NUM_PLANES-1:0] all_now, any_now, corner_b;
  logic [CORNER_W-1:0]   cnt_q, cnt_d;
  logic                  valid_d, valid_q;
  logic [1:0]            vis_d, vis_q;
  logic                  last_corner;

  assign n_active = (planes_in_use_i > PIU_W'(NUM_PLANES)) ? PIU_W'(NUM_PLANES)
                                                           : planes_in_use_i;

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      active[p]   = (PIU_W'(p) < n_active);
      corner_b[p] = behind_i[p][0];
    end
  end

  assign last_corner = (cnt_q == CORNER_W'(BOX_CORNERS - 1));

  always_comb begin
    all_d   = all_q;
    any_d   = any_q;
    cnt_d   = cnt_q;
    valid_d = 1'b0;
    vis_d   = VIS_FULL;
    all_now = '0;
    any_now = '0;
    case (ctrl_i.func)
      FUNC_POINT: begin
        valid_d = ctrl_i.valid;
        if ((corner_b & active) != '0) begin
          vis_d = VIS_INVISIBLE;
        end
      end
      FUNC_BOX, FUNC_CORNER: begin
        for (int p = 0; p < NUM_PLANES; p++) begin
          if (ctrl_i.func == FUNC_BOX) begin
            all_now[p] = &behind_i[p];
            any_now[p] = |behind_i[p];
          end else begin
            all_now[p] = all_q[p] & corner_b[p];
            any_now[p] = any_q[p] | corner_b[p];
          end
        end
        if ((all_now & active) != '0) begin
          vis_d = VIS_INVISIBLE;
        end else if ((any_now & active) != '0) begin
          vis_d = VIS_PARTIAL;
        end
        if (ctrl_i.func == FUNC_BOX) begin
          valid_d = ctrl_i.valid;
        end else if (ctrl_i.valid) begin
          if (last_corner) begin
            valid_d = 1'b1;
            all_d   = '1;
            any_d   = '0;
            cnt_d   = '0;
          end else begin
            all_d = all_now;
            any_d = any_now;
            cnt_d = cnt_q + CORNER_W'(1);
          end
        end
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      all_q   <= '1;
      any_q   <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else if (advance_i) begin
      all_q   <= all_d;
      any_q   <= any_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      vis_q <= vis_d;
    end
  end

  assign valid_o = valid_q;
  assign vis_o   = vis_q;

  // An unused selector never yields a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && ctrl_i.valid && ctrl_i.func != FUNC_POINT && ctrl_i.func != FUNC_BOX
     && ctrl_i.func != FUNC_CORNER) |=> !valid_q)
    else $error("fbv_merge: result produced for an unused selector");

  // The eighth corner closes the box and restarts the corner count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && ctrl_i.valid && ctrl_i.func == FUNC_CORNER && last_corner)
      |=> (cnt_q == '0 && valid_q && any_q == '0))
    else $error("fbv_merge: corner state not cleared after the eighth corner");

  // A plane with every received corner behind it has at least one corner behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> ((all_q & ~any_q) == '0))
    else $error("fbv_merge: all-behind flag set without any-behind flag");

  // Before the eighth corner, corner items only advance the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && ctrl_i.valid && ctrl_i.func == FUNC_CORNER && !last_corner)
      |=> (!valid_q && cnt_q == $past(cnt_q) + CORNER_W'(1)))
    else $error("fbv_merge: early corner produced a result or lost count");

endmodule

### rtl/frustum_box_visibility.sv
// Top level of the frustum box visibility block.
// Instantiates one fbv_lane per plane and fbv_merge; uses fbv_pkg.
//
// This block tests a point or an axis-aligned box against up to six frustum
// planes and answers invisible, partially visible or fully visible. Each input
// transfer carries a selector on tuser: a point test, a min/max box test, or one
// corner of an eight-corner box, where only the eighth corner yields a result
// transfer and the first seven yield none. Selector code 3 is dropped silently.
// The block takes one input transfer every clock cycle and holds it only while
// the output register is full and not being taken. Each plane has a lane of its
// own: the first stage forms the six normal-times-bound products, the second
// sums them into the eight corner distances and compares each against the
// threshold, and a merge stage combines the lanes and the streamed-corner state
// into the output register. Write the plane and planes_in_use registers only
// while the block is empty; a planes_in_use value above six counts as six, and
// zero makes every test answer fully visible.
module frustum_box_visibility import fbv_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // Fields from bit 0: min_x, min_y, min_z, max_x, max_y, max_z (16 bits each).
  input  logic [95:0]  s_axis_tdata_i,
  // Fields from bit 0: func.
  input  logic [1:0]   s_axis_tuser_i,
  // Output stream.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // Fields from bit 0: visibility (2 bits), then zero fill.
  output logic [7:0]   m_axis_tdata_o,
  // Configuration writes.
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_wdata_i
);

  logic [PLANE_W-1:0]                     plane_q [NUM_PLANES];
  logic [PIU_W-1:0]                       piu_q;
  logic                                   advance;
  ctrl_t                                  s1_q, s2_q;
  coord3_t                                lo, hi;
  logic [NUM_PLANES-1:0][BOX_CORNERS-1:0] behind;
  logic                                   res_valid;
  logic [1:0]                             res_vis;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        plane_q[p] <= '0;
      end
      piu_q <= PIU_RESET;
    end else if (cfg_we_i) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        if (cfg_idx_i == 3'(p)) begin
          plane_q[p] <= cfg_wdata_i;
        end
      end
      if (cfg_idx_i == REG_PLANES_IN_USE) begin
        piu_q <= cfg_wdata_i[PIU_W-1:0];
      end
    end
  end

  // The whole pipeline moves together whenever the output register can take
  // a new value.
  assign advance         = !res_valid || m_axis_tready_i;
  assign s_axis_tready_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (advance) begin
      s1_q.valid <= s_axis_tvalid_i;
      s1_q.func  <= s_axis_tuser_i;
      s2_q       <= s1_q;
    end
  end

  assign lo = s_axis_tdata_i[47:0];
  assign hi = s_axis_tdata_i[95:48];

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    fbv_lane u_lane (
      .clk_i     (clk_i),
      .advance_i (advance),
      .plane_i   (plane_q[p]),
      .lo_i      (lo),
      .hi_i      (hi),
      .behind_o  (behind[p])
    );
  end

  fbv_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .ctrl_i          (s2_q),
    .behind_i        (behind),
    .planes_in_use_i (piu_q),
    .valid_o         (res_valid),
    .vis_o           (res_vis)
  );

  assign m_axis_tvalid_o = res_valid;
  assign m_axis_tdata_o  = {6'b0, res_vis};

endmodule

### test/fbv_visibility_check.sv
// Checker for the frustum box visibility block: tracks the plane registers,
// computes the expected result of every input that yields one and compares results.
// Depends on fbv_pkg for widths and codes.
module fbv_visibility_check import fbv_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  // Fields from bit 0: min_x, min_y, min_z, max_x, max_y, max_z.
  input  logic [95:0]  s_axis_tdata_i,
  // Fields from bit 0: func.
  input  logic [1:0]   s_axis_tuser_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  // Fields from bit 0: visibility, then zero fill.
  input  logic [7:0]   m_axis_tdata_i,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_wdata_i,
  output int           mismatches_o,
  output int           outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PLANE_W-1:0]  plane_q [NUM_PLANES];
  logic [PIU_W-1:0]    planes_used_q;
  logic [3:0]          behind_tally [NUM_PLANES];
  logic [CORNER_W-1:0] corners_in;
  logic [1:0]          vis_due [$];

  // A position is behind a plane when n.p + d, at scale 2^-22, is below -8388.
  function automatic logic behind_plane(logic [PLANE_W-1:0] w, coord3_t p);
    longint plane_sum;
    plane_sum = longint'($signed(w[15:0])) * longint'($signed(p[0]))
              + longint'($signed(w[31:16])) * longint'($signed(p[1]))
              + longint'($signed(w[47:32])) * longint'($signed(p[2]))
              + longint'($signed(w[63:48])) * longint'(16384);
    return plane_sum < -longint'(BEHIND_LIMIT);
  endfunction

  function automatic int live_planes();
    return (planes_used_q > NUM_PLANES) ? NUM_PLANES : int'(planes_used_q);
  endfunction

  function automatic logic [1:0] grade(logic [NUM_PLANES-1:0][3:0] tally);
    logic [1:0] vis;
    vis = VIS_FULL;
    for (int pl = 0; pl < live_planes(); pl++) begin
      if (tally[pl] >= BOX_CORNERS) return VIS_INVISIBLE;
      if (tally[pl] != 0) vis = VIS_PARTIAL;
    end
    return vis;
  endfunction

  function automatic logic [1:0] point_vis(coord3_t p);
    for (int pl = 0; pl < live_planes(); pl++) begin
      if (behind_plane(plane_q[pl], p)) return VIS_INVISIBLE;
    end
    return VIS_FULL;
  endfunction

  function automatic logic [1:0] box_vis(coord3_t lo, coord3_t hi);
    coord3_t corner;
    logic [NUM_PLANES-1:0][3:0] tally;
    tally = '0;
    for (int pl = 0; pl < NUM_PLANES; pl++) begin
      for (int c = 0; c < BOX_CORNERS; c++) begin
        corner[0] = (c & 1) ? hi[0] : lo[0];
        corner[1] = (c & 2) ? hi[1] : lo[1];
        corner[2] = (c & 4) ? hi[2] : lo[2];
        if (behind_plane(plane_q[pl], corner)) tally[pl] = tally[pl] + 4'd1;
      end
    end
    return grade(tally);
  endfunction

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    coord3_t lo;
    coord3_t hi;
    logic [7:0] want;
    logic [NUM_PLANES-1:0][3:0] snap;
    if (!rst_ni) begin
      for (int pl = 0; pl < NUM_PLANES; pl++) begin
        plane_q[pl] = '0;
        behind_tally[pl] = '0;
      end
      planes_used_q = PIU_RESET;
      corners_in = '0;
      vis_due.delete();
      mismatches_o = 0;
      outstanding_o = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        lo = s_axis_tdata_i[47:0];
        hi = s_axis_tdata_i[95:48];
        case (s_axis_tuser_i)
          FUNC_POINT: vis_due.push_back(point_vis(lo));
          FUNC_BOX: vis_due.push_back(box_vis(lo, hi));
          FUNC_CORNER: begin
            for (int pl = 0; pl < NUM_PLANES; pl++) begin
              if (behind_plane(plane_q[pl], lo) && behind_tally[pl] != 4'd15)
                behind_tally[pl] = behind_tally[pl] + 4'd1;
            end
            if (corners_in != CORNER_W'(BOX_CORNERS - 1)) begin
              corners_in = corners_in + 1'b1;
            end else begin
              for (int pl = 0; pl < NUM_PLANES; pl++) begin
                snap[pl] = behind_tally[pl];
                behind_tally[pl] = '0;
              end
              vis_due.push_back(grade(snap));
              corners_in = '0;
            end
          end
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (vis_due.size() == 0) begin
          report($sformatf("unexpected result transfer, tdata %0d", m_axis_tdata_i));
        end else begin
          want = {6'b0, vis_due.pop_front()};
          if (m_axis_tdata_i != want)
            report($sformatf("visibility expected %0d, got %0d", want, m_axis_tdata_i));
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i < NUM_PLANES) plane_q[cfg_idx_i] = cfg_wdata_i;
        else if (cfg_idx_i == REG_PLANES_IN_USE) planes_used_q = cfg_wdata_i[PIU_W-1:0];
      end
      outstanding_o = vis_due.size();
    end
  end

endmodule

### test/testbench.sv
// Top of the frustum box visibility testbench: clock, reset, stimulus and verdict.
// Instantiates frustum_box_visibility and fbv_visibility_check; uses fbv_pkg.
// The checker predicts and compares; this module only drives and judges.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fbv_pkg::*;

  // Plane register indexes on the configuration port; planes_in_use comes
  // from the package.
  localparam logic [2:0] REG_PLANE_LEFT   = 3'd0;
  localparam logic [2:0] REG_PLANE_RIGHT  = 3'd1;
  localparam logic [2:0] REG_PLANE_TOP    = 3'd2;
  localparam logic [2:0] REG_PLANE_BOTTOM = 3'd3;
  localparam logic [2:0] REG_PLANE_NEAR   = 3'd4;
  localparam logic [2:0] REG_PLANE_FAR    = 3'd5;

  // The selector code that the block drops without a result.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Half range of the ordinary random coordinates, in Q8.8 (about 19.5 units),
  // so that boxes land inside, across and outside the configured frustums.
  localparam int SPAN = 5000;
  localparam int ONE  = 256;
  localparam int UNIT_NORMAL = 16384;

  logic        clk;
  logic        rst_n;
  logic        s_valid;
  logic        s_ready;
  logic [95:0] s_data;
  logic [1:0]  s_user;
  logic        m_valid;
  logic        m_ready;
  logic [7:0]  m_data;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [63:0] cfg_wdata;
  int          mismatches;
  int          outstanding;

  // Per-phase switches for sender gaps and receiver stalls.
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;

  // Box whose corners are being streamed.
  int box_lo [3];
  int box_hi [3];

  frustum_box_visibility i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  fbv_visibility_check i_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .mismatches_o    (mismatches),
    .outstanding_o   (outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int spread(int a);
    return int'($urandom_range(0, 2 * a)) - a;
  endfunction

  // Mostly coordinates near the frustum, now and then any 16-bit value so
  // that every bit of every field toggles.
  function automatic int coord();
    if ($urandom_range(0, 7) == 0) return int'($urandom_range(0, 65535));
    return spread(SPAN);
  endfunction

  function automatic logic [15:0] extreme16();
    case ($urandom_range(0, 3))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [PLANE_W-1:0] plane_word(int nx, int ny, int nz, int d);
    return {16'(d), 16'(nz), 16'(ny), 16'(nx)};
  endfunction

  // An axis-aligned frustum (a box of half sizes hx, hy, hz when the normal
  // magnitude is 1.0), with each normal optionally tilted by small random
  // components. Left, bottom and near face the positive axis.
  function automatic logic [NUM_PLANES-1:0][PLANE_W-1:0] frustum(int hx, int hy, int hz,
                                                                 int mag, int tilt);
    int half [3];
    int n [3];
    int sgn;
    logic [NUM_PLANES-1:0][PLANE_W-1:0] pl;
    half = '{hx, hy, hz};
    for (int k = 0; k < NUM_PLANES; k++) begin
      sgn = (k == 0 || k == 3 || k == 4) ? 1 : -1;
      for (int a = 0; a < 3; a++) n[a] = (tilt == 0) ? 0 : spread(tilt);
      n[k / 2] = sgn * mag;
      pl[k] = plane_word(n[0], n[1], n[2], half[k / 2]);
    end
    return pl;
  endfunction

  // Gaps between input transfers: most short, a few long.
  function automatic int idle_cycles();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // One input transfer. Values change at the falling edge, and tready is read
  // at the rising edge, before the block updates its registers.
  task automatic send_item(logic [1:0] func, int lx, int ly, int lz, int hx, int hy, int hz);
    int gap;
    gap = idle_cycles();
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= func;
    s_data  <= {16'(hz), 16'(hy), 16'(hx), 16'(lz), 16'(ly), 16'(lx)};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_point(logic [1:0] func, int x, int y, int z);
    send_item(func, x, y, z, coord(), coord(), coord());
  endtask

  task automatic send_corner(int c);
    send_point(FUNC_CORNER, (c & 1) ? box_hi[0] : box_lo[0],
               (c & 2) ? box_hi[1] : box_lo[1], (c & 4) ? box_hi[2] : box_lo[2]);
  endtask

  task automatic set_box(int lx, int ly, int lz, int hx, int hy, int hz);
    box_lo = '{lx, ly, lz};
    box_hi = '{hx, hy, hz};
  endtask

  // A random box: a small extent above a random low corner, sometimes inverted,
  // sometimes spanning any 16-bit values.
  task automatic pick_box();
    int e;
    int t;
    for (int a = 0; a < 3; a++) begin
      if ($urandom_range(0, 7) == 0) begin
        box_lo[a] = int'($urandom_range(0, 65535));
        box_hi[a] = int'($urandom_range(0, 65535));
      end else begin
        e = $urandom_range(0, 4 * ONE);
        box_lo[a] = spread(SPAN);
        box_hi[a] = box_lo[a] + e;
      end
      if ($urandom_range(0, 9) == 0) begin
        t = box_lo[a];
        box_lo[a] = box_hi[a];
        box_hi[a] = t;
      end
    end
  endtask

  // A well-formed eight-corner stream with random content. Point tests and
  // dropped selectors are slipped in between corners now and then, and a
  // corner is sometimes replaced by an unrelated position.
  task automatic random_stream();
    for (int c = 0; c < BOX_CORNERS; c++) begin
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 1) == 0) send_point(FUNC_POINT, coord(), coord(), coord());
        else send_point(FUNC_UNUSED, coord(), coord(), coord());
      end
      if ($urandom_range(0, 9) == 0) send_point(FUNC_CORNER, coord(), coord(), coord());
      else send_corner(c);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic load_planes(logic [NUM_PLANES-1:0][PLANE_W-1:0] pl, logic [PIU_W-1:0] count);
    write_reg(REG_PLANE_LEFT, pl[0]);
    write_reg(REG_PLANE_RIGHT, pl[1]);
    write_reg(REG_PLANE_TOP, pl[2]);
    write_reg(REG_PLANE_BOTTOM, pl[3]);
    write_reg(REG_PLANE_NEAR, pl[4]);
    write_reg(REG_PLANE_FAR, pl[5]);
    write_reg(REG_PLANES_IN_USE, 64'(count));
    cfg_we <= 1'b0;
  endtask

  // Registers may only change while the block is empty. A streamed corner that
  // yields no result may still be in the pipeline when the last result has
  // arrived, so the task keeps waiting after the last result is taken.
  task automatic settle();
    s_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Receiver: ready is dropped at random, mostly for short stretches and
  // sometimes for long ones, and never while stalls are off.
  initial begin : receiver
    int hold;
    hold = 0;
    m_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        hold--;
      end else if (stalls_on && $urandom_range(0, 2) == 0) begin
        m_ready <= 1'b0;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end else begin
        m_ready <= 1'b1;
        hold = $urandom_range(0, 5);
      end
    end
  end

  initial begin : stimulus
    logic [NUM_PLANES-1:0][PLANE_W-1:0] pl;
    logic [PIU_W-1:0] count;
    int sent;
    int pick;
    rst_n     = 1'b0;
    s_valid   = 1'b0;
    s_data    = '0;
    s_user    = FUNC_POINT;
    cfg_we    = 1'b0;
    cfg_idx   = REG_PLANE_LEFT;
    cfg_wdata = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Out of reset every plane is zero, so nothing is ever behind and even
    // the extreme coordinates are fully visible.
    send_item(FUNC_POINT, -32768, -32768, -32768, 32767, 32767, 32767);
    send_item(FUNC_BOX, -32768, -32768, -32768, 32767, 32767, 32767);

    // A cube frustum of half size 8.0 with unit normals.
    settle();
    load_planes(frustum(8 * ONE, 8 * ONE, 8 * ONE, UNIT_NORMAL, 0), PIU_W'(NUM_PLANES));
    send_point(FUNC_POINT, 0, 0, 0);
    send_point(FUNC_POINT, -9 * ONE, 0, 0);
    send_item(FUNC_BOX, -ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_item(FUNC_BOX, -9 * ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_item(FUNC_BOX, 9 * ONE, 0, 0, 10 * ONE, ONE, ONE);
    // Inverted box: the corners are formed as given.
    send_item(FUNC_BOX, ONE, ONE, ONE, -9 * ONE, -ONE, -ONE);
    send_item(FUNC_BOX, -32768, -32768, -32768, 32767, 32767, 32767);
    // A streamed box crossing the left plane, with a point test, a dropped
    // selector and a min/max box test arriving mid-stream.
    set_box(-9 * ONE, -ONE, -ONE, ONE, ONE, ONE);
    for (int c = 0; c < BOX_CORNERS; c++) begin
      if (c == 4) begin
        send_point(FUNC_POINT, -9 * ONE, 0, 0);
        send_point(FUNC_UNUSED, 0, 0, 0);
      end
      if (c == 6) send_item(FUNC_BOX, -ONE, -ONE, -ONE, ONE, ONE, ONE);
      send_corner(c);
    end

    // Threshold edge: a plane with the smallest x normal and no offset, so the
    // distance is x itself; -8388 is still in front and -8389 is behind. A
    // planes_in_use of seven counts as six.
    settle();
    pl = '0;
    pl[0] = plane_word(1, 0, 0, 0);
    load_planes(pl, 3'd7);
    send_point(FUNC_POINT, -8388, 0, 0);
    send_point(FUNC_POINT, -8389, 0, 0);

    // With no planes in use every test answers fully visible.
    settle();
    load_planes(frustum(8 * ONE, 8 * ONE, 8 * ONE, UNIT_NORMAL, 0), 3'd0);
    send_item(FUNC_BOX, 9 * ONE, 0, 0, 10 * ONE, ONE, ONE);
    send_point(FUNC_POINT, -32768, -32768, -32768);

    // Random phases, each with its own planes, plane count and idling.
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      pick = (ph == 0) ? 3 : (ph == 1) ? 2 : $urandom_range(0, 3);
      if (pick < 2) begin
        pl = frustum($urandom_range(0, 16 * ONE), $urandom_range(0, 16 * ONE),
                     $urandom_range(0, 16 * ONE), $urandom_range(4096, 32767), 2048);
      end else if (pick == 2) begin
        for (int k = 0; k < NUM_PLANES; k++) pl[k] = {$urandom, $urandom};
      end else begin
        for (int k = 0; k < NUM_PLANES; k++)
          pl[k] = {extreme16(), extreme16(), extreme16(), extreme16()};
      end
      count = ($urandom_range(0, 9) < 7) ? PIU_W'(NUM_PLANES) : PIU_W'($urandom_range(0, 7));
      load_planes(pl, count);
      sent = 0;
      while (sent < 50) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          pick_box();
          random_stream();
          sent += BOX_CORNERS;
        end else if (pick < 7) begin
          pick_box();
          send_item(FUNC_BOX, box_lo[0], box_lo[1], box_lo[2], box_hi[0], box_hi[1], box_hi[2]);
          sent++;
        end else if (pick < 9) begin
          send_point(FUNC_POINT, coord(), coord(), coord());
          sent++;
        end else begin
          send_item(FUNC_UNUSED, coord(), coord(), coord(), coord(), coord(), coord());
        end
      end
    end

    // Drain, then allow a few cycles for any result that should not come.
    s_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest run with every gap and stall at its longest.
  initial begin : watchdog
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
